// ===== sv/mtfe_pkg.sv =====
// ----------------------------------------------------------------------------
// mtfe_pkg: shared types for the move-to-front encoder
// Word widths and the token that travels down the cell chain.
// ----------------------------------------------------------------------------
package mtfe_pkg;

    localparam int SYMBOL_W = 8;
    localparam int RANK_W   = 8;

    // Token carried from cell to cell, one cell per cycle while the chain advances
    typedef struct packed {
        logic                rst;    // restore identity value in each cell passed
        logic                found;  // symbol already located, pass through
        logic [SYMBOL_W-1:0] sym;    // symbol being coded
        logic [SYMBOL_W-1:0] carry;  // value displaced from the previous cell
        logic [RANK_W-1:0]   rank;   // position where the symbol was found
    } token_t;

endpackage

// ===== sv/mtfe_cell.sv =====
// ----------------------------------------------------------------------------
// mtfe_cell: one entry of the recency list
// Holds one list value; a passing token not yet found swaps in its carry,
// and records this position as the rank if the held value equals the symbol.
// ----------------------------------------------------------------------------
module mtfe_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            in_valid,
    input  mtfe_pkg::token_t in_tok,
    output logic            out_valid,
    output mtfe_pkg::token_t out_tok
);

    localparam logic [mtfe_pkg::SYMBOL_W-1:0] IDX = mtfe_pkg::SYMBOL_W'(CELL_INDEX);

    logic [mtfe_pkg::SYMBOL_W-1:0] value_reg, value_next;
    logic [mtfe_pkg::SYMBOL_W-1:0] old_value;
    logic                          valid_reg;
    mtfe_pkg::token_t              tok_reg, tok_next;

    always_comb begin
        old_value  = in_tok.rst ? IDX : value_reg;
        value_next = value_reg;
        tok_next   = in_tok;
        if (advance && in_valid) begin
            if (!in_tok.found) begin
                // take the displaced value, pass ours on unless it is the symbol
                value_next = in_tok.carry;
                if (old_value == in_tok.sym) begin
                    tok_next.found = 1'b1;
                    tok_next.rank  = mtfe_pkg::RANK_W'(CELL_INDEX);
                end else begin
                    tok_next.carry = old_value;
                end
            end else begin
                value_next = old_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= IDX;
            valid_reg <= 1'b0;
        end else begin
            value_reg <= value_next;
            if (advance) begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            tok_reg <= tok_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule

// ===== sv/move_to_front_encoder.sv =====
// ----------------------------------------------------------------------------
// move_to_front_encoder: byte-wise move-to-front coder
// Systolic chain of ALPHABET_SIZE list cells with in-order rank output.
// ----------------------------------------------------------------------------
// Each accepted byte enters a chain of ALPHABET_SIZE cells as a token that
// moves one cell per cycle while the chain advances, swapping the list one
// entry at a time, so a new byte can enter every cycle and the block sustains
// one word per cycle unless stalled. Every token walks the full chain through
// a register in each cell, and ranks leave the result port in input order.
// The whole chain holds while a result waits on m_ready. With s_block_start
// set, the list is restored to identity order before that byte is coded.
// An out-of-alphabet byte yields rank 0 and moves no entry to the front.
module move_to_front_encoder #(
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mtfe_pkg::SYMBOL_W-1:0] s_symbol,
    input  logic                          s_block_start,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mtfe_pkg::RANK_W-1:0]   m_rank
);

    logic             advance;
    logic             out_of_range;
    mtfe_pkg::token_t head_tok;
    logic             chain_valid [ALPHABET_SIZE];
    mtfe_pkg::token_t chain_tok   [ALPHABET_SIZE];

    // hold the chain while the last cell has a word nobody took
    assign advance = !chain_valid[ALPHABET_SIZE-1] || m_ready;
    assign s_ready = advance;

    assign out_of_range = {1'b0, s_symbol} >= (mtfe_pkg::SYMBOL_W+1)'(ALPHABET_SIZE);

    always_comb begin
        head_tok.rst   = s_block_start;
        head_tok.found = out_of_range;
        head_tok.sym   = s_symbol;
        head_tok.carry = s_symbol;
        head_tok.rank  = '0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < ALPHABET_SIZE; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                mtfe_cell #(.CELL_INDEX(gi)) u_cell (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .advance   (advance),
                    .in_valid  (s_valid),
                    .in_tok    (head_tok),
                    .out_valid (chain_valid[gi]),
                    .out_tok   (chain_tok[gi])
                );
            end else begin : g_body
                mtfe_cell #(.CELL_INDEX(gi)) u_cell (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .advance   (advance),
                    .in_valid  (chain_valid[gi-1]),
                    .in_tok    (chain_tok[gi-1]),
                    .out_valid (chain_valid[gi]),
                    .out_tok   (chain_tok[gi])
                );
            end
        end
    endgenerate

    assign m_valid = chain_valid[ALPHABET_SIZE-1];
    assign m_rank  = chain_tok[ALPHABET_SIZE-1].rank;

endmodule
